[sv/hkd_pkg.sv]
// Shared constants, widths and a helper function of the heatmap keypoint decoder.
package hkd_pkg;

   localparam int KEYPOINTS_DEFAULT = 17;
   localparam int MAX_MAP_WIDTH_DEFAULT = 64;
   localparam int MAX_MAP_HEIGHT_DEFAULT = 64;

   localparam int HEAT_W = 16;
   localparam int KP_INDEX_W = 5;
   localparam int POS_W = 12;
   localparam int SCORE_W = 9;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 10;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_MAP_WIDTH = 3'd0,
      REG_MAP_HEIGHT = 3'd1,
      REG_REFINE_ENABLE = 3'd2,
      REG_REFINE_SHIFT = 3'd3,
      REG_MIN_PEAK_DISTANCE = 3'd4
   } reg_index_type;

   // operand width of the shared multiplier
   localparam int MUL_W = 18;
   localparam int PROD_W = 2 * MUL_W;

   localparam logic [6:0] MAP_WIDTH_RESET = 7'd48;
   localparam logic [6:0] MAP_HEIGHT_RESET = 7'd64;
   localparam logic REFINE_ENABLE_RESET = 1'b1;
   localparam logic [7:0] REFINE_SHIFT_RESET = 8'd64;
   localparam logic [9:0] MIN_PEAK_DISTANCE_RESET = 10'd48;

   // number of search steps of the refinement offset (sixteenths of a cell)
   localparam logic [4:0] STEP_LAST = 5'd16;

   // floor(n / 510) = (n * SCORE_RECIP) >> SCORE_SHIFT, exact for n < 66052
   localparam logic [MUL_W-1:0] SCORE_RECIP = 18'd65794;
   localparam int SCORE_SHIFT = 25;
   localparam logic [MUL_W-1:0] SCORE_ROUND = 18'd255;
   localparam logic signed [9:0] SCORE_MID = 10'sd128;
   localparam logic signed [9:0] SCORE_MAX = 10'sd256;

   localparam logic [POS_W-1:0] POS_MAX = 12'd4095;
   localparam int PIXEL_OFFSET = 32;

   // ((2k-1)*16)^2, the square of the k-th rounding boundary
   function automatic logic [MUL_W-1:0] step_sq(input logic [4:0] k);
      logic [MUL_W-1:0] a;
      a = MUL_W'({k, 5'b0}) - MUL_W'(16);
      return MUL_W'(a * a);
   endfunction

endpackage

[sv/hkd_mul.sv]
// Shared unsigned multiplier with a registered product.
module hkd_mul (
   input  logic                        clock,
   input  logic [hkd_pkg::MUL_W-1:0]   op_a,
   input  logic [hkd_pkg::MUL_W-1:0]   op_b,
   output logic [hkd_pkg::PROD_W-1:0]  prod
);

   logic [hkd_pkg::PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= hkd_pkg::PROD_W'(op_a) * hkd_pkg::PROD_W'(op_b);
   end

   assign prod = prod_ff;

endmodule

[sv/hkd_heat_mem.sv]
// Heatmap value store: one write port, one registered read port.
module hkd_heat_mem #(
   parameter int DEPTH = 69632,
   parameter int AW = 17
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [AW-1:0]                    wr_addr,
   input  logic signed [hkd_pkg::HEAT_W-1:0] wr_data,
   input  logic                             rd_en,
   input  logic [AW-1:0]                    rd_addr,
   output logic signed [hkd_pkg::HEAT_W-1:0] rd_data
);

   logic signed [hkd_pkg::HEAT_W-1:0] mem_ff [DEPTH];
   logic signed [hkd_pkg::HEAT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/heatmap_keypoint_decode.sv]
// Top level of the heatmap keypoint decoder: scan counters, peak trackers and finish sequencer.
//
// Use: heatmap values arrive on the req_ channel in row, column, channel order, one
// transaction per cycle while req_ready is high; req_last_of_map marks the final value.
// Each value inside the map height is written to the heat store and folded into the peak
// and runner-up trackers of its channel in the same cycle.
// After the last value the block drops req_ready and walks the keypoints one after the
// other through a sequencer around a single shared multiplier, giving one rsp_
// transaction per keypoint, last_keypoint on the final one. With refinement a keypoint runs
// two 16-step offset searches on the multiplier; while the receiver holds rsp_ready low,
// the result register simply holds its transaction and the sequencer waits.
// Registers are written on the csr_ channel while the block is idle. A write of the map
// width in the middle of a map re-derives row and column from the cell count by
// repeated subtraction, then recomputes row base and address on the multiplier, without req_ready.
// Reset (synchronous) restores register defaults, clears the trackers and the scan
// position; the heat store is not cleared and needs no clearing pass.
module heatmap_keypoint_decode #(
   parameter int KEYPOINTS = hkd_pkg::KEYPOINTS_DEFAULT,
   parameter int MAX_MAP_WIDTH = hkd_pkg::MAX_MAP_WIDTH_DEFAULT,
   parameter int MAX_MAP_HEIGHT = hkd_pkg::MAX_MAP_HEIGHT_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [hkd_pkg::HEAT_W-1:0]    req_heat_value,
   input  logic                                 req_last_of_map,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [hkd_pkg::KP_INDEX_W-1:0]       rsp_keypoint_index,
   output logic [hkd_pkg::POS_W-1:0]            rsp_pos_x,
   output logic [hkd_pkg::POS_W-1:0]            rsp_pos_y,
   output logic [hkd_pkg::SCORE_W-1:0]          rsp_score,
   output logic                                 rsp_last_keypoint,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [hkd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [hkd_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int CW = (MAX_MAP_WIDTH > 1) ? $clog2(MAX_MAP_WIDTH) : 1;
   localparam int RW = (MAX_MAP_HEIGHT > 1) ? $clog2(MAX_MAP_HEIGHT) : 1;
   localparam int WW = $clog2(MAX_MAP_WIDTH + 1);
   localparam int HW = $clog2(MAX_MAP_HEIGHT + 1);
   localparam int CLW = $clog2(MAX_MAP_WIDTH * MAX_MAP_HEIGHT + 1);
   localparam int KW = (KEYPOINTS > 1) ? $clog2(KEYPOINTS) : 1;
   localparam int DEPTH = MAX_MAP_WIDTH * MAX_MAP_HEIGHT * KEYPOINTS;
   localparam int AW = $clog2(DEPTH);
   localparam int ROW_STEP = MAX_MAP_WIDTH * KEYPOINTS;
   localparam int XW = CW + 6;
   localparam int YW = RW + 6;
   localparam int CXW = CW + 4;
   localparam int CYW = RW + 4;
   localparam int PXW = CW + 7;
   localparam int PYW = RW + 7;
   localparam int MW = hkd_pkg::MUL_W;
   localparam int PW = hkd_pkg::PROD_W;

   typedef enum logic [4:0] {
      ST_COLLECT, ST_DIV, ST_RS1, ST_RS2, ST_RS3,
      ST_LOAD, ST_SXX, ST_SYY, ST_SUM, ST_TEST, ST_T, ST_RHS, ST_ITER,
      ST_POS, ST_RND, ST_A1, ST_A2, ST_RD, ST_SC, ST_OUT
   } state_type;

   typedef struct packed {
      logic signed [hkd_pkg::HEAT_W-1:0] value;
      logic [RW-1:0]                     row;
      logic [CW-1:0]                     col;
   } track_type;

   // configuration
   logic [6:0] map_width_ff, map_height_ff;
   logic       refine_enable_ff;
   logic [7:0] refine_shift_ff;
   logic [9:0] min_peak_distance_ff;
   logic [WW-1:0] w_eff;
   logic [HW-1:0] h_eff;

   // scan position
   state_type state_ff, state_in;
   logic [KW-1:0]  ch_ff, ch_in;
   logic [CW-1:0]  col_ff, col_in;
   logic [CLW-1:0] row_ff, row_in;
   logic [CLW-1:0] cell_ff, cell_in;
   logic [CLW-1:0] rem_ff, rem_in;
   logic [AW-1:0]  rowbase_ff, rowbase_in;
   logic [AW-1:0]  addr_ff, addr_in;

   // trackers
   track_type peak_ff [KEYPOINTS];
   track_type runner_ff [KEYPOINTS];
   track_type peak_rd, runner_rd, peak_in, runner_in;
   logic      trk_we;
   logic [KW-1:0] trk_idx;

   // finish sequencer
   logic [KW-1:0] c_ff, c_in;
   logic [RW-1:0] pr_ff, pr_in, rr_ff, rr_in;
   logic [CW-1:0] pc_ff, pc_in, rc_ff, rc_in;
   logic [MW-1:0] acc_ff, acc_in, s_ff, s_in;
   logic [PW-1:0] rhs_ff, rhs_in;
   logic          refine_ff, refine_in, axis_ff, axis_in;
   logic [4:0]    k_ff, k_in, q_ff, q_in, qx_ff, qx_in, qy_ff, qy_in;
   logic [CXW-1:0] cx_ff, cx_in;
   logic [CYW-1:0] cy_ff, cy_in;
   logic [CW-1:0]  rx_ff, rx_in;
   logic           neg_ff, neg_in;

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   logic [hkd_pkg::POS_W-1:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [hkd_pkg::SCORE_W-1:0] score_ff, score_in;

   // shared units
   logic [MW-1:0] mul_a, mul_b;
   logic [PW-1:0] prod;
   logic mem_we, mem_re;
   logic [AW-1:0] mem_raddr;
   logic signed [hkd_pkg::HEAT_W-1:0] mem_rdata;

   // combinational helpers
   logic accept, store;
   logic signed [CW:0] dxs;
   logic signed [RW:0] dys;
   logic [CW-1:0] adx;
   logic [RW-1:0] ady;
   logic [4:0] q_new;
   logic signed [XW-1:0] x16, offx;
   logic signed [YW-1:0] y16, offy;
   logic [XW-1:0] hix;
   logic [YW-1:0] hiy;
   logic [CXW:0] rxs;
   logic [CYW:0] rys;
   logic [MW-1:0] nabs;
   logic signed [9:0] sc;
   logic [PXW-1:0] pixx;
   logic [PYW-1:0] pixy;

   hkd_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   hkd_heat_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (addr_ff),
      .wr_data (req_heat_value),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   always_comb begin
      if (map_width_ff == 7'd0) begin
         w_eff = WW'(1);
      end else if (32'(map_width_ff) > MAX_MAP_WIDTH) begin
         w_eff = WW'(MAX_MAP_WIDTH);
      end else begin
         w_eff = WW'(map_width_ff);
      end
      if (map_height_ff == 7'd0) begin
         h_eff = HW'(1);
      end else if (32'(map_height_ff) > MAX_MAP_HEIGHT) begin
         h_eff = HW'(MAX_MAP_HEIGHT);
      end else begin
         h_eff = HW'(map_height_ff);
      end
   end

   // registers only change between transactions, never while keypoints are being finished
   assign csr_ready = (state_ff == ST_COLLECT);
   // a register write goes ahead of a value offered in the same cycle
   assign req_ready = (state_ff == ST_COLLECT) && !csr_valid;
   assign accept = req_valid && req_ready;
   assign store = 32'(row_ff) < 32'(h_eff);
   assign mem_we = accept && store;

   assign trk_idx = (state_ff == ST_COLLECT) ? ch_ff : c_ff;
   assign peak_rd = peak_ff[trk_idx];
   assign runner_rd = runner_ff[trk_idx];

   always_comb begin
      dxs = $signed({1'b0, rc_ff}) - $signed({1'b0, pc_ff});
      dys = $signed({1'b0, rr_ff}) - $signed({1'b0, pr_ff});
      adx = dxs[CW] ? CW'(-dxs) : CW'(dxs);
      ady = dys[RW] ? RW'(-dys) : RW'(dys);
      q_new = (prod <= rhs_ff) ? k_ff : q_ff;
      offx = refine_ff ? (dxs[CW] ? -$signed(XW'(qx_ff)) : $signed(XW'(qx_ff))) : '0;
      offy = refine_ff ? (dys[RW] ? -$signed(YW'(qy_ff)) : $signed(YW'(qy_ff))) : '0;
      x16 = $signed(XW'({pc_ff, 4'b0})) + offx;
      y16 = $signed(YW'({pr_ff, 4'b0})) + offy;
      hix = XW'({w_eff - WW'(1), 4'b0});
      hiy = YW'({h_eff - HW'(1), 4'b0});
      rxs = (CXW + 1)'(cx_ff) + (CXW + 1)'(8);
      rys = (CYW + 1)'(cy_ff) + (CYW + 1)'(8);
      nabs = MW'(mem_rdata[hkd_pkg::HEAT_W-1] ? -(17'(mem_rdata)) : 17'(mem_rdata));
      sc = neg_ff ? hkd_pkg::SCORE_MID - $signed(10'(prod >> hkd_pkg::SCORE_SHIFT))
                  : hkd_pkg::SCORE_MID + $signed(10'(prod >> hkd_pkg::SCORE_SHIFT));
      pixx = PXW'({cx_ff, 2'b0}) + PXW'(hkd_pkg::PIXEL_OFFSET);
      pixy = PYW'({cy_ff, 2'b0}) + PYW'(hkd_pkg::PIXEL_OFFSET);
   end

   always_comb begin
      state_in = state_ff;
      ch_in = ch_ff;
      col_in = col_ff;
      row_in = row_ff;
      cell_in = cell_ff;
      rem_in = rem_ff;
      rowbase_in = rowbase_ff;
      addr_in = addr_ff;
      trk_we = 1'b0;
      peak_in = peak_rd;
      runner_in = runner_rd;
      c_in = c_ff;
      pr_in = pr_ff;
      pc_in = pc_ff;
      rr_in = rr_ff;
      rc_in = rc_ff;
      acc_in = acc_ff;
      s_in = s_ff;
      rhs_in = rhs_ff;
      refine_in = refine_ff;
      axis_in = axis_ff;
      k_in = k_ff;
      q_in = q_ff;
      qx_in = qx_ff;
      qy_in = qy_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      rx_in = rx_ff;
      neg_in = neg_ff;
      rsp_valid_in = rsp_valid_ff;
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      score_in = score_ff;
      mul_a = '0;
      mul_b = '0;
      mem_re = 1'b0;
      mem_raddr = AW'(prod) + AW'(c_ff);

      case (state_ff)
         ST_COLLECT: begin
            if (accept && store) begin
               trk_we = 1'b1;
               if (cell_ff == '0) begin
                  peak_in = '{value: req_heat_value, row: '0, col: '0};
                  runner_in = peak_in;
               end else if (req_heat_value > runner_rd.value) begin
                  if (req_heat_value > peak_rd.value) begin
                     runner_in = peak_rd;
                     peak_in = '{value: req_heat_value, row: RW'(row_ff), col: col_ff};
                  end else begin
                     runner_in = '{value: req_heat_value, row: RW'(row_ff), col: col_ff};
                  end
               end
               addr_in = addr_ff + AW'(1);
               if (ch_ff == KW'(KEYPOINTS - 1)) begin
                  ch_in = '0;
                  cell_in = cell_ff + CLW'(1);
                  if (32'(col_ff) == 32'(w_eff) - 1) begin
                     col_in = '0;
                     row_in = row_ff + CLW'(1);
                     rowbase_in = rowbase_ff + AW'(ROW_STEP);
                     addr_in = rowbase_ff + AW'(ROW_STEP);
                  end else begin
                     col_in = col_ff + CW'(1);
                  end
               end else begin
                  ch_in = ch_ff + KW'(1);
               end
            end
            if (accept && req_last_of_map) begin
               ch_in = '0;
               col_in = '0;
               row_in = '0;
               cell_in = '0;
               rowbase_in = '0;
               addr_in = '0;
               c_in = '0;
               state_in = ST_LOAD;
            end
         end
         ST_DIV: begin
            if (32'(rem_ff) >= 32'(w_eff)) begin
               rem_in = rem_ff - CLW'(w_eff);
               row_in = row_ff + CLW'(1);
            end else begin
               col_in = CW'(rem_ff);
               state_in = ST_RS1;
            end
         end
         ST_RS1: begin
            mul_a = MW'(row_ff);
            mul_b = MW'(ROW_STEP);
            state_in = ST_RS2;
         end
         ST_RS2: begin
            rowbase_in = AW'(prod);
            mul_a = MW'(col_ff);
            mul_b = MW'(KEYPOINTS);
            state_in = ST_RS3;
         end
         ST_RS3: begin
            addr_in = rowbase_ff + AW'(prod) + AW'(ch_ff);
            state_in = ST_COLLECT;
         end
         ST_LOAD: begin
            pr_in = peak_rd.row;
            pc_in = peak_rd.col;
            rr_in = runner_rd.row;
            rc_in = runner_rd.col;
            state_in = ST_SXX;
         end
         ST_SXX: begin
            mul_a = MW'(adx);
            mul_b = MW'(adx);
            state_in = ST_SYY;
         end
         ST_SYY: begin
            acc_in = MW'(prod);
            mul_a = MW'(ady);
            mul_b = MW'(ady);
            state_in = ST_SUM;
         end
         ST_SUM: begin
            s_in = acc_ff + MW'(prod);
            mul_a = MW'(min_peak_distance_ff);
            mul_b = MW'(min_peak_distance_ff);
            state_in = ST_TEST;
         end
         ST_TEST: begin
            // refine only when enabled and 256 * dist^2 exceeds the squared threshold
            refine_in = refine_enable_ff && ((PW'(s_ff) << 8) > prod);
            axis_in = 1'b0;
            mul_a = MW'(refine_shift_ff);
            mul_b = MW'(adx);
            state_in = refine_in ? ST_T : ST_POS;
         end
         ST_T: begin
            mul_a = MW'(prod) << 1;
            mul_b = MW'(prod) << 1;
            state_in = ST_RHS;
         end
         ST_RHS: begin
            rhs_in = prod;
            q_in = '0;
            k_in = 5'd1;
            mul_a = hkd_pkg::step_sq(5'd1);
            mul_b = s_ff;
            state_in = ST_ITER;
         end
         ST_ITER: begin
            q_in = q_new;
            if (k_ff == hkd_pkg::STEP_LAST) begin
               if (!axis_ff) begin
                  qx_in = q_new;
                  axis_in = 1'b1;
                  mul_a = MW'(refine_shift_ff);
                  mul_b = MW'(ady);
                  state_in = ST_T;
               end else begin
                  qy_in = q_new;
                  state_in = ST_POS;
               end
            end else begin
               k_in = k_ff + 5'd1;
               mul_a = hkd_pkg::step_sq(k_ff + 5'd1);
               mul_b = s_ff;
            end
         end
         ST_POS: begin
            if (x16 < 0) begin
               cx_in = '0;
            end else if (x16 > $signed(hix)) begin
               cx_in = CXW'(hix);
            end else begin
               cx_in = CXW'(x16);
            end
            if (y16 < 0) begin
               cy_in = '0;
            end else if (y16 > $signed(hiy)) begin
               cy_in = CYW'(hiy);
            end else begin
               cy_in = CYW'(y16);
            end
            state_in = ST_RND;
         end
         ST_RND: begin
            // a clamped position never rounds beyond the last cell
            rx_in = CW'(rxs >> 4);
            mul_a = MW'(rys >> 4);
            mul_b = MW'(MAX_MAP_WIDTH);
            state_in = ST_A1;
         end
         ST_A1: begin
            mul_a = MW'(prod) + MW'(rx_ff);
            mul_b = MW'(KEYPOINTS);
            state_in = ST_A2;
         end
         ST_A2: begin
            mem_re = 1'b1;
            state_in = ST_RD;
         end
         ST_RD: begin
            neg_in = mem_rdata[hkd_pkg::HEAT_W-1];
            mul_a = (nabs << 1) + hkd_pkg::SCORE_ROUND;
            mul_b = hkd_pkg::SCORE_RECIP;
            state_in = ST_SC;
         end
         ST_SC: begin
            if (sc < 0) begin
               score_in = '0;
            end else if (sc > hkd_pkg::SCORE_MAX) begin
               score_in = hkd_pkg::SCORE_W'(hkd_pkg::SCORE_MAX);
            end else begin
               score_in = hkd_pkg::SCORE_W'(sc);
            end
            pos_x_in = (32'(pixx) > 32'(hkd_pkg::POS_MAX)) ? hkd_pkg::POS_MAX
                                                           : hkd_pkg::POS_W'(pixx);
            pos_y_in = (32'(pixy) > 32'(hkd_pkg::POS_MAX)) ? hkd_pkg::POS_MAX
                                                           : hkd_pkg::POS_W'(pixy);
            rsp_valid_in = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (c_ff == KW'(KEYPOINTS - 1)) begin
                  c_in = '0;
                  state_in = ST_COLLECT;
               end else begin
                  c_in = c_ff + KW'(1);
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase

      // new width mid-map: re-derive row and column from the cell count
      if (csr_valid && csr_ready && csr_index == hkd_pkg::REG_MAP_WIDTH) begin
         rem_in = cell_ff;
         row_in = '0;
         state_in = ST_DIV;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
         map_width_ff <= hkd_pkg::MAP_WIDTH_RESET;
         map_height_ff <= hkd_pkg::MAP_HEIGHT_RESET;
         refine_enable_ff <= hkd_pkg::REFINE_ENABLE_RESET;
         refine_shift_ff <= hkd_pkg::REFINE_SHIFT_RESET;
         min_peak_distance_ff <= hkd_pkg::MIN_PEAK_DISTANCE_RESET;
         ch_ff <= '0;
         col_ff <= '0;
         row_ff <= '0;
         cell_ff <= '0;
         rowbase_ff <= '0;
         addr_ff <= '0;
         c_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < KEYPOINTS; i++) begin
            peak_ff[i] <= '0;
            runner_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         ch_ff <= ch_in;
         col_ff <= col_in;
         row_ff <= row_in;
         cell_ff <= cell_in;
         rowbase_ff <= rowbase_in;
         addr_ff <= addr_in;
         c_ff <= c_in;
         rsp_valid_ff <= rsp_valid_in;
         if (trk_we) begin
            peak_ff[ch_ff] <= peak_in;
            runner_ff[ch_ff] <= runner_in;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               hkd_pkg::REG_MAP_WIDTH:         map_width_ff <= csr_data[6:0];
               hkd_pkg::REG_MAP_HEIGHT:        map_height_ff <= csr_data[6:0];
               hkd_pkg::REG_REFINE_ENABLE:     refine_enable_ff <= csr_data[0];
               hkd_pkg::REG_REFINE_SHIFT:      refine_shift_ff <= csr_data[7:0];
               hkd_pkg::REG_MIN_PEAK_DISTANCE: min_peak_distance_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
      rem_ff <= rem_in;
      pr_ff <= pr_in;
      pc_ff <= pc_in;
      rr_ff <= rr_in;
      rc_ff <= rc_in;
      acc_ff <= acc_in;
      s_ff <= s_in;
      rhs_ff <= rhs_in;
      refine_ff <= refine_in;
      axis_ff <= axis_in;
      k_ff <= k_in;
      q_ff <= q_in;
      qx_ff <= qx_in;
      qy_ff <= qy_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      rx_ff <= rx_in;
      neg_ff <= neg_in;
      pos_x_ff <= pos_x_in;
      pos_y_ff <= pos_y_in;
      score_ff <= score_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_keypoint_index = hkd_pkg::KP_INDEX_W'(c_ff);
   assign rsp_pos_x = pos_x_ff;
   assign rsp_pos_y = pos_y_ff;
   assign rsp_score = score_ff;
   assign rsp_last_keypoint = (c_ff == KW'(KEYPOINTS - 1));

endmodule
